// ===== design/rpn_pkg.sv =====
package rpn_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int DEPTH_W     = 6;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [3:0] OP_PUSH  = 4'd0;
   localparam logic [3:0] OP_ADD   = 4'd1;
   localparam logic [3:0] OP_SUB   = 4'd2;
   localparam logic [3:0] OP_MUL   = 4'd3;
   localparam logic [3:0] OP_DIV   = 4'd4;
   localparam logic [3:0] OP_NEG   = 4'd5;
   localparam logic [3:0] OP_DROP  = 4'd6;
   localparam logic [3:0] OP_CLEAR = 4'd7;
   localparam logic [3:0] OP_SUM   = 4'd8;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FEW    = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_DIVZ   = 2'd3;

   localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

   typedef enum logic [2:0] {
      K_PUSH, K_BIN, K_NEG, K_DROP, K_CLEAR, K_SUM, K_NOP
   } kind_type;

   // classified command handed from front to back
   typedef struct packed {
      kind_type    kind;
      logic [3:0]  op;
      logic [63:0] value;
   } cmd_type;

endpackage

// ===== design/rpn_front.sv =====
module rpn_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [71:0]     req_tdata,
   output logic            cmd_valid,
   input  logic            cmd_ready,
   output rpn_pkg::cmd_type cmd
);
   import rpn_pkg::*;

   localparam int QA_W = $clog2(QUEUE_DEPTH);

   cmd_type              q_ff [QUEUE_DEPTH];
   logic [QA_W-1:0]      wr_ff, wr_in, rd_ff, rd_in;
   logic [QA_W:0]        cnt_ff, cnt_in;
   cmd_type              c;
   logic                 push, pop;

   always_comb begin
      c.op    = req_tdata[3:0];
      c.value = req_tdata[67:4];
      unique case (c.op)
         OP_PUSH:                        c.kind = K_PUSH;
         OP_ADD, OP_SUB, OP_MUL, OP_DIV: c.kind = K_BIN;
         OP_NEG:                         c.kind = K_NEG;
         OP_DROP:                        c.kind = K_DROP;
         OP_CLEAR:                       c.kind = K_CLEAR;
         OP_SUM:                         c.kind = K_SUM;
         default:                        c.kind = K_NOP;
      endcase
   end

   assign req_tready = (cnt_ff != QUEUE_DEPTH[QA_W:0]);
   assign cmd_valid  = (cnt_ff != '0);
   assign cmd        = q_ff[rd_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = cmd_valid && cmd_ready;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + {{QA_W{1'b0}}, push} - {{QA_W{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) q_ff[wr_ff] <= c;
   end
endmodule

// ===== design/rpn_back.sv =====
module rpn_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  rpn_pkg::cmd_type cmd,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [79:0]      rsp_tdata
);
   import rpn_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RD_B  = 4'd1;
   localparam logic [3:0] S_RD_A  = 4'd2;
   localparam logic [3:0] S_EXEC  = 4'd3;
   localparam logic [3:0] S_MUL   = 4'd4;
   localparam logic [3:0] S_DIV   = 4'd5;
   localparam logic [3:0] S_SUMRD = 4'd6;
   localparam logic [3:0] S_SUMAC = 4'd7;
   localparam logic [3:0] S_WRITE = 4'd8;
   localparam logic [3:0] S_TOP   = 4'd9;
   localparam logic [3:0] S_TOPW  = 4'd10;
   localparam logic [3:0] S_OUT   = 4'd11;

   logic [63:0]        mem [STACK_DEPTH];
   logic [63:0]        rdata_ff;
   logic [ADDR_W-1:0]  raddr;
   logic               rd_en;
   logic [ADDR_W-1:0]  waddr;
   logic [63:0]        wdata;
   logic               wr_en;

   logic [3:0]         st_ff, st_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   cmd_type            cmd_ff, cmd_in;
   logic [63:0]        a_ff, a_in, b_ff, b_in, r_ff, r_in;
   logic [1:0]         status_ff, status_in;
   logic [CNT_W-1:0]   clr_ff, clr_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic               wr_ff, wr_in;
   logic [79:0]        out_ff, out_in;
   logic               ov_ff, ov_in;
   // multiply: 64x64 in 4 partial products of 32x32
   logic [1:0]         mstep_ff, mstep_in;
   logic [127:0]       macc_ff, macc_in;
   logic [63:0]        pp;
   // divide: restoring, one bit a cycle over 96 bits
   logic [6:0]         dstep_ff, dstep_in;
   logic [95:0]        dnum_ff, dnum_in;
   logic [64:0]        drem_ff, drem_in;
   logic [63:0]        dq_ff, dq_in;
   logic               dovf_ff, dovf_in;
   // sum accumulator
   logic [69:0]        sacc_ff, sacc_in;

   logic [63:0]        ma, mb;
   logic               rneg;
   logic [64:0]        rsh, rdf;
   logic [64:0]        sum65, dif65;

   function automatic logic [63:0] from_mag(logic [63:0] m, logic neg, logic ovf);
      if (neg) return (ovf || m > SMIN) ? SMIN : (64'd0 - m);
      return (ovf || m > SMAX) ? SMAX : m;
   endfunction

   assign ma   = a_ff[63] ? 64'd0 - a_ff : a_ff;
   assign mb   = b_ff[63] ? 64'd0 - b_ff : b_ff;
   assign rneg = a_ff[63] ^ b_ff[63];
   assign sum65 = {a_ff[63], a_ff} + {b_ff[63], b_ff};
   assign dif65 = {a_ff[63], a_ff} - {b_ff[63], b_ff};

   always_comb begin
      unique case (mstep_ff)
         2'd0:    pp = {32'd0, ma[31:0]} * {32'd0, mb[31:0]};
         2'd1:    pp = {32'd0, ma[63:32]} * {32'd0, mb[31:0]};
         2'd2:    pp = {32'd0, ma[31:0]} * {32'd0, mb[63:32]};
         default: pp = {32'd0, ma[63:32]} * {32'd0, mb[63:32]};
      endcase
   end

   assign rsh = {drem_ff[63:0], dnum_ff[95]};
   assign rdf = rsh - {1'b0, mb};

   assign cmd_ready = (st_ff == S_IDLE);
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = out_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[waddr] <= wdata;
      if (rd_en) rdata_ff <= mem[raddr];
   end

   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; cmd_in = cmd_ff;
      a_in = a_ff; b_in = b_ff; r_in = r_ff;
      status_in = status_ff; clr_in = clr_ff; idx_in = idx_ff; wr_in = wr_ff;
      out_in = out_ff; ov_in = ov_ff;
      mstep_in = mstep_ff; macc_in = macc_ff;
      dstep_in = dstep_ff; dnum_in = dnum_ff; drem_in = drem_ff;
      dq_in = dq_ff; dovf_in = dovf_ff; sacc_in = sacc_ff;
      rd_en = 1'b0; raddr = '0; wr_en = 1'b0; waddr = '0; wdata = r_ff;

      if (ov_ff && rsp_tready) ov_in = 1'b0;

      unique case (st_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_in = cmd; status_in = ST_OK; clr_in = '0; wr_in = 1'b0;
               st_in = S_TOP;
               unique case (cmd.kind)
                  K_PUSH: begin
                     if (cnt_ff >= CNT_W'(STACK_DEPTH)) status_in = ST_FULL;
                     else begin
                        r_in = cmd.value; idx_in = cnt_ff; wr_in = 1'b1;
                        cnt_in = cnt_ff + 1'b1; st_in = S_WRITE;
                     end
                  end
                  K_BIN: begin
                     if (cnt_ff < CNT_W'(2)) status_in = ST_FEW;
                     else st_in = S_RD_B;
                  end
                  K_NEG: begin
                     if (cnt_ff == '0) status_in = ST_FEW;
                     else st_in = S_RD_B;
                  end
                  K_DROP: if (cnt_ff != '0) cnt_in = cnt_ff - 1'b1;
                  K_CLEAR: begin
                     clr_in = cnt_ff; cnt_in = '0;
                  end
                  K_SUM: begin
                     sacc_in = '0; idx_in = '0; st_in = S_SUMRD;
                  end
                  default: ;
               endcase
            end
         end
         S_RD_B: begin
            rd_en = 1'b1; raddr = ADDR_W'(cnt_ff - 1'b1);
            st_in = (cmd_ff.kind == K_NEG) ? S_EXEC : S_RD_A;
         end
         S_RD_A: begin
            b_in = rdata_ff;
            rd_en = 1'b1; raddr = ADDR_W'(cnt_ff - CNT_W'(2));
            st_in = S_EXEC;
         end
         S_EXEC: begin
            if (cmd_ff.kind == K_NEG) begin
               // negate runs as 0 - top through the subtract path
               a_in = 64'd0; b_in = rdata_ff; cmd_in.op = OP_SUB;
               idx_in = cnt_ff - 1'b1; st_in = S_MUL;
            end else begin
               a_in = rdata_ff;
               idx_in = cnt_ff - CNT_W'(2);
               unique case (cmd_ff.op)
                  OP_DIV: begin
                     if (b_ff == 64'd0) begin
                        status_in = ST_DIVZ; st_in = S_TOP;
                     end else begin
                        st_in = S_DIV; dstep_in = '0; drem_in = '0; dq_in = '0;
                        dovf_in = 1'b0;
                        dnum_in = {(rdata_ff[63] ? 64'd0 - rdata_ff : rdata_ff), 32'd0};
                     end
                  end
                  OP_MUL: begin
                     st_in = S_MUL; mstep_in = '0; macc_in = '0;
                  end
                  default: st_in = S_MUL;
               endcase
            end
         end
         S_MUL: begin
            unique case (cmd_ff.op)
               OP_ADD: begin
                  r_in = (sum65[64] != sum65[63]) ? (a_ff[63] ? SMIN : SMAX) : sum65[63:0];
                  st_in = S_WRITE; wr_in = 1'b1; cnt_in = cnt_ff - 1'b1;
               end
               OP_SUB: begin
                  r_in = (dif65[64] != dif65[63]) ? (a_ff[63] ? SMIN : SMAX) : dif65[63:0];
                  st_in = S_WRITE; wr_in = 1'b1;
                  if (cmd_ff.kind == K_BIN && idx_ff == cnt_ff - CNT_W'(2))
                     cnt_in = cnt_ff - 1'b1;
               end
               default: begin
                  unique case (mstep_ff)
                     2'd0: macc_in = macc_ff + {64'd0, pp};
                     2'd1, 2'd2: macc_in = macc_ff + {32'd0, pp, 32'd0};
                     default: macc_in = macc_ff + {pp, 64'd0};
                  endcase
                  mstep_in = mstep_ff + 1'b1;
                  if (mstep_ff == 2'd3) st_in = S_DIV;
               end
            endcase
         end
         S_DIV: begin
            if (cmd_ff.op == OP_MUL) begin
               r_in = from_mag(macc_ff[95:32], rneg, macc_ff[127:96] != 32'd0);
               st_in = S_WRITE; wr_in = 1'b1; cnt_in = cnt_ff - 1'b1;
            end else begin
               dnum_in = {dnum_ff[94:0], 1'b0};
               if (drem_ff[63] || !rdf[64]) begin
                  drem_in = rdf;
                  if (dstep_ff < 7'd32) dovf_in = 1'b1;
                  else dq_in = {dq_ff[62:0], 1'b1};
               end else begin
                  drem_in = rsh;
                  if (dstep_ff >= 7'd32) dq_in = {dq_ff[62:0], 1'b0};
               end
               dstep_in = dstep_ff + 1'b1;
               if (dstep_ff == 7'd95) st_in = S_SUMAC;
            end
         end
         S_SUMRD: begin
            if (cmd_ff.kind == K_SUM) begin
               if (idx_ff < cnt_ff) begin
                  rd_en = 1'b1; raddr = ADDR_W'(idx_ff); st_in = S_SUMAC;
               end else begin
                  if (sacc_ff[69:63] == 7'd0 || sacc_ff[69:63] == 7'h7F)
                     r_in = sacc_ff[63:0];
                  else r_in = sacc_ff[69] ? SMIN : SMAX;
                  idx_in = '0; cnt_in = CNT_W'(1); wr_in = 1'b1; st_in = S_WRITE;
               end
            end
         end
         S_SUMAC: begin
            if (cmd_ff.kind == K_SUM) begin
               sacc_in = sacc_ff + {{6{rdata_ff[63]}}, rdata_ff};
               idx_in = idx_ff + 1'b1; st_in = S_SUMRD;
            end else begin
               r_in = from_mag(dq_ff, rneg, dovf_ff);
               st_in = S_WRITE; wr_in = 1'b1; cnt_in = cnt_ff - 1'b1;
            end
         end
         S_WRITE: begin
            wr_en = wr_ff; waddr = ADDR_W'(idx_ff); wdata = r_ff;
            st_in = S_TOP;
         end
         S_TOP: begin
            rd_en = (cnt_ff != '0); raddr = ADDR_W'(cnt_ff - 1'b1);
            st_in = S_TOPW;
         end
         S_TOPW: begin
            if (!ov_ff || rsp_tready) begin
               out_in = {2'b00, DEPTH_W'(clr_ff), DEPTH_W'(cnt_ff),
                         (cnt_ff != '0) ? rdata_ff : 64'd0, status_ff};
               ov_in = 1'b1; st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; cnt_ff <= '0; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in; ov_ff <= ov_in;
      end
      cmd_ff <= cmd_in; a_ff <= a_in; b_ff <= b_in; r_ff <= r_in;
      status_ff <= status_in; clr_ff <= clr_in; idx_ff <= idx_in; wr_ff <= wr_in;
      out_ff <= out_in; mstep_ff <= mstep_in; macc_ff <= macc_in;
      dstep_ff <= dstep_in; dnum_ff <= dnum_in; drem_ff <= drem_in;
      dq_ff <= dq_in; dovf_ff <= dovf_in; sacc_ff <= sacc_in;
   end
endmodule

// ===== design/rpn_stack_calculator.sv =====
// Postfix stack calculator on signed Q32.32 values, stack of 32 entries held in
// a single-port-read memory. Each item gives one result. Multiply forms four
// 32x32 partial products in sequence; divide uses a restoring divider, one bit
// a cycle over 96 bits; sum-all reads the entries in turn through the one
// memory read port. A result waiting on rsp_tready holds the back end at its
// last step. A two-entry queue in front lets the next items be taken while one
// is being worked on.
module rpn_stack_calculator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // op[3:0], value[67:4], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata   // status[1:0], top_value[65:2], depth[71:66],
                                   // clear_count[77:72], zero pad
);
   import rpn_pkg::*;

   logic    cmd_valid, cmd_ready;
   cmd_type cmd;

   rpn_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .cmd_valid, .cmd_ready, .cmd
   );

   rpn_back u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );
endmodule

// ===== design/rpn_checker.sv =====
module rpn_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [71:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata
);
   import rpn_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while stalled");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[71:66] <= 6'(STACK_DEPTH))
      else $error("depth beyond stack size");

   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[71:66] == 6'd0 |-> rsp_tdata[65:2] == 64'd0)
      else $error("empty stack shows nonzero top");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[77:72] != 6'd0 |-> rsp_tdata[71:66] == 6'd0)
      else $error("clear left entries");
endmodule

bind rpn_stack_calculator rpn_checker u_checker (
   .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
   .rsp_tvalid, .rsp_tready, .rsp_tdata
);

// ===== tb/rpn_stack_calculator_tb.sv =====
module rpn_stack_calculator_tb;
   import rpn_pkg::*;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] top_value;
      logic [5:0]  depth;
      logic [5:0]  cleared;
   } calc_result_type;

   typedef struct {
      logic [3:0]   op;
      logic [63:0]  value;
      bit           typed;
      calc_result_type res;
   } step_row_type;

   localparam logic [63:0] ONE_Q = 64'h0000_0001_0000_0000;
   localparam int N_DIRECTED = 23;
   localparam int N_RANDOM   = 950;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;

   rpn_stack_calculator DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // predictor state
   logic [63:0] calc_stack [STACK_DEPTH];
   int          calc_count = 0;

   calc_result_type pending_results[$];
   step_row_type    directed_rows[N_DIRECTED];
   int           items_in = 0;
   int           results_out = 0;
   int           mismatches = 0;
   int           full_seen = 0;
   int           divz_seen = 0;
   int           few_seen = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("rpn_stack_calculator verification failed");
      $finish;
   end

   function automatic logic [63:0] clamp_wide(input logic signed [71:0] s);
      if (s > $signed({8'h00, SMAX})) return SMAX;
      if (s < $signed({8'hFF, SMIN})) return SMIN;
      return s[63:0];
   endfunction

   function automatic logic [63:0] from_magnitude(input logic [127:0] m, input bit neg);
      if (neg) return (m > {64'd0, SMIN}) ? SMIN : (64'd0 - m[63:0]);
      return (m > {64'd0, SMAX}) ? SMAX : m[63:0];
   endfunction

   function automatic logic [127:0] magnitude(input logic [63:0] v);
      return {64'd0, v[63] ? (64'd0 - v) : v};
   endfunction

   function automatic logic [63:0] fix_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = magnitude(a) * magnitude(b);
      return from_magnitude(p >> 32, a[63] ^ b[63]);
   endfunction

   function automatic logic [63:0] fix_div(input logic [63:0] n, input logic [63:0] d);
      logic [127:0] q;
      q = (magnitude(n) << 32) / magnitude(d);
      return from_magnitude(q, n[63] ^ d[63]);
   endfunction

   function automatic calc_result_type calc_step(input logic [3:0] op,
                                                 input logic [63:0] value);
      calc_result_type r;
      logic [63:0] a, b;
      logic signed [71:0] acc;
      r = '0;
      case (op)
         OP_PUSH: begin
            if (calc_count >= STACK_DEPTH) r.status = ST_FULL;
            else begin
               calc_stack[calc_count] = value;
               calc_count++;
            end
         end
         OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            if (calc_count < 2) r.status = ST_FEW;
            else begin
               a = calc_stack[calc_count-2];
               b = calc_stack[calc_count-1];
               if (op == OP_DIV && b == 0) r.status = ST_DIVZ;
               else begin
                  case (op)
                     OP_ADD: a = clamp_wide(72'($signed(a)) + 72'($signed(b)));
                     OP_SUB: a = clamp_wide(72'($signed(a)) - 72'($signed(b)));
                     OP_MUL: a = fix_mul(a, b);
                     default: a = fix_div(a, b);
                  endcase
                  calc_count--;
                  calc_stack[calc_count-1] = a;
               end
            end
         end
         OP_NEG: begin
            if (calc_count < 1) r.status = ST_FEW;
            else calc_stack[calc_count-1] =
               clamp_wide(72'sd0 - $signed(calc_stack[calc_count-1]));
         end
         OP_DROP: if (calc_count > 0) calc_count--;
         OP_CLEAR: begin
            r.cleared = calc_count[5:0];
            calc_count = 0;
         end
         OP_SUM: begin
            acc = 0;
            for (int i = 0; i < calc_count; i++) acc += $signed(calc_stack[i]);
            calc_stack[0] = clamp_wide(acc);
            calc_count = 1;
         end
         default: ;
      endcase
      r.top_value = calc_count ? calc_stack[calc_count-1] : 64'd0;
      r.depth = calc_count[5:0];
      return r;
   endfunction

   // accepted items feed the predictor; directed rows with typed results use those
   always @(posedge clock) begin
      calc_result_type r;
      if (!reset && req_tvalid && req_tready) begin
         r = calc_step(req_tdata[3:0], req_tdata[67:4]);
         if (items_in < N_DIRECTED && directed_rows[items_in].typed)
            r = directed_rows[items_in].res;
         pending_results.push_back(r);
         items_in++;
      end
   end

   always @(posedge clock) begin
      calc_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[1:0], rsp_tdata[65:2], rsp_tdata[71:66], rsp_tdata[77:72]};
         results_out++;
         if (got.status == ST_FULL) full_seen++;
         if (got.status == ST_DIVZ) divz_seen++;
         if (got.status == ST_FEW) few_seen++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: status %0d/%0d top %h/%h depth %0d/%0d clr %0d/%0d",
                     results_out, want.status, got.status, want.top_value, got.top_value,
                     want.depth, got.depth, want.cleared, got.cleared);
            end
         end
      end
   end

   // receiver: phases of always-ready, coin flips and long stalls
   int rx_mode = 0, rx_phase = 0, rx_hold = 0;
   always @(posedge clock) begin
      if (rx_phase == 0) begin
         rx_mode <= $urandom_range(0, 2);
         rx_phase <= $urandom_range(20, 120);
      end else rx_phase <= rx_phase - 1;
      if (rx_hold > 0) begin
         rx_hold <= rx_hold - 1;
         rsp_tready <= 1'b0;
      end else case (rx_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= $urandom_range(0, 1);
         default: begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 7) == 0) rx_hold <= $urandom_range(1, 15);
         end
      endcase
   end

   int burst_left = 0;

   task automatic send_item(input logic [3:0] op, input logic [63:0] value);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if ($urandom_range(0, 2) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {4'd0, value, op};
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [63:0] rand_value();
      case ($urandom_range(0, 9))
         0: return 64'd0;
         1: return ONE_Q;
         2: return 64'd0 - ONE_Q;
         3: return SMAX;
         4: return SMIN;
         5: return {{32{1'b0}}, 32'($urandom)};
         6: return {{24{$urandom_range(0, 1) == 1}}, 8'($urandom), 32'($urandom)};
         7: return 64'($signed(8'($urandom))) << $urandom_range(24, 40);
         default: return {32'($urandom), 32'($urandom)};
      endcase
   endfunction

   function automatic logic [3:0] rand_op();
      int w;
      w = $urandom_range(0, 99);
      if (w < 40) return OP_PUSH;
      if (w < 50) return OP_ADD;
      if (w < 58) return OP_SUB;
      if (w < 68) return OP_MUL;
      if (w < 76) return OP_DIV;
      if (w < 82) return OP_NEG;
      if (w < 88) return OP_DROP;
      if (w < 91) return OP_CLEAR;
      if (w < 96) return OP_SUM;
      return 4'($urandom_range(9, 15));
   endfunction

   task automatic wait_drained();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      int sent;
      directed_rows = '{
         '{OP_DROP,  64'd0, 1, '{ST_OK,   64'd0, 6'd0, 6'd0}},
         '{OP_ADD,   64'd0, 1, '{ST_FEW,  64'd0, 6'd0, 6'd0}},
         '{OP_NEG,   64'd0, 1, '{ST_FEW,  64'd0, 6'd0, 6'd0}},
         '{OP_SUM,   64'd0, 1, '{ST_OK,   64'd0, 6'd1, 6'd0}},
         '{OP_CLEAR, 64'd0, 1, '{ST_OK,   64'd0, 6'd0, 6'd1}},
         '{OP_PUSH,  SMAX,  1, '{ST_OK,   SMAX,  6'd1, 6'd0}},
         '{OP_PUSH,  64'd1, 1, '{ST_OK,   64'd1, 6'd2, 6'd0}},
         '{OP_ADD,   64'd0, 1, '{ST_OK,   SMAX,  6'd1, 6'd0}},
         '{OP_PUSH,  SMIN,  1, '{ST_OK,   SMIN,  6'd2, 6'd0}},
         '{OP_NEG,   64'd0, 1, '{ST_OK,   SMAX,  6'd2, 6'd0}},
         '{OP_PUSH,  SMIN,  1, '{ST_OK,   SMIN,  6'd3, 6'd0}},
         '{OP_PUSH,  64'd0, 1, '{ST_OK,   64'd0, 6'd4, 6'd0}},
         '{OP_DIV,   64'd0, 1, '{ST_DIVZ, 64'd0, 6'd4, 6'd0}},
         '{OP_DROP,  64'd0, 1, '{ST_OK,   SMIN,  6'd3, 6'd0}},
         '{OP_PUSH,  ONE_Q, 0, '0},
         '{OP_MUL,   64'd0, 0, '0},
         '{OP_SUB,   64'd0, 0, '0},
         '{OP_PUSH,  3*ONE_Q, 0, '0},
         '{OP_DIV,   64'd0, 0, '0},
         '{OP_SUM,   64'd0, 0, '0},
         '{4'd9,     ~64'd0, 0, '0},
         '{4'd15,    64'd5, 0, '0},
         '{OP_CLEAR, 64'd0, 0, '0}
      };
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i]) send_item(directed_rows[i].op, directed_rows[i].value);
      req_tvalid <= 1'b0;
      wait_drained();

      sent = 0;
      while (sent < N_RANDOM) begin
         if ($urandom_range(0, 9) == 0) begin
            // run the stack to full and past it, then sum it or multiply the top two
            send_item(OP_CLEAR, rand_value());
            repeat (STACK_DEPTH + 2) send_item(OP_PUSH, rand_value());
            send_item($urandom_range(0, 1) ? OP_SUM : OP_MUL, 64'd0);
            sent += STACK_DEPTH + 4;
         end else begin
            repeat ($urandom_range(4, 16)) begin
               send_item(rand_op(), rand_value());
               sent++;
            end
         end
      end
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("items %0d results %0d: full %0d, divide-by-zero %0d, too-few %0d",
         items_in, results_out, full_seen, divz_seen, few_seen);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("rpn_stack_calculator verification clean");
      else begin
         $display("mismatches %0d, left over %0d", mismatches, pending_results.size());
         $display("rpn_stack_calculator verification failed");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
design/rpn_pkg.sv
design/rpn_front.sv
design/rpn_back.sv
design/rpn_stack_calculator.sv
design/rpn_checker.sv
tb/rpn_stack_calculator_tb.sv
